### rtl/spa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial adder package
// Shared term and command word types, kind codes and queue sizing.
// ----------------------------------------------------------------------------
package spa_pkg;

  // Input kind codes
  localparam logic [1:0] KIND_FIRST  = 2'd0;
  localparam logic [1:0] KIND_SECOND = 2'd1;
  localparam logic [1:0] KIND_ADD    = 2'd2;

  // Command queue sizing
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOAD_FIRST,
    OP_LOAD_SECOND,
    OP_ADD
  } op_t;

  typedef struct packed {
    logic signed [31:0] coeff;
    logic [15:0]        power;
  } term_t;

  typedef struct packed {
    op_t   op;
    term_t term;
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_MERGE
  } state_t;

endpackage

### rtl/spa_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial adder front end
// Accepts input words, decodes the kind into a command and holds it in a
// one-word stage until the command queue takes it. Unused kinds are dropped.
// ----------------------------------------------------------------------------
module spa_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [1:0]    kind,
  input  logic [31:0]   coeff,
  input  logic [15:0]   power,
  output logic          push,
  output spa_pkg::cmd_t push_cmd,
  input  logic          q_full
);
  import spa_pkg::*;

  logic hold_valid;
  cmd_t hold;
  cmd_t decoded;
  logic keep;
  logic accept;

  // Decode the kind of the incoming word
  always_comb begin
    decoded.term.coeff = coeff;
    decoded.term.power = power;
    decoded.op         = OP_ADD;
    keep               = 1'b1;
    case (kind)
      KIND_FIRST:  decoded.op = OP_LOAD_FIRST;
      KIND_SECOND: decoded.op = OP_LOAD_SECOND;
      KIND_ADD:    decoded.op = OP_ADD;
      default:     keep = 1'b0;
    endcase
  end

  assign push     = hold_valid && !q_full;
  assign in_stall = hold_valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign push_cmd = hold;

  // Hold stage: load on accept, release on push
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= keep;
    end else if (push) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold <= decoded;
    end
  end

endmodule

### rtl/spa_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial adder command queue
// Small FIFO between the front end and the merge engine.
// ----------------------------------------------------------------------------
module spa_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  spa_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output spa_pkg::cmd_t head
);
  import spa_pkg::*;

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

endmodule

### rtl/spa_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial adder merge engine
// Executes queued commands: loads terms into the two stores; an add merges
// both stores in sorted order, one result word per cycle unless stalled.
// ----------------------------------------------------------------------------
module spa_back #(
  parameter int MAX_TERMS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  spa_pkg::cmd_t      q_cmd,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [32:0] sum_coeff,
  output logic [15:0]        sum_power,
  output logic               last,
  output logic               truncated,
  output logic               empty_res
);
  import spa_pkg::*;

  localparam int CNT_W = $clog2(MAX_TERMS + 1);
  localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  term_t             first_terms  [MAX_TERMS];
  term_t             second_terms [MAX_TERMS];
  logic [CNT_W-1:0]  first_count;
  logic [CNT_W-1:0]  second_count;
  logic              dropped_flag;
  logic [CNT_W-1:0]  i_pos;
  logic [CNT_W-1:0]  j_pos;
  state_t            state;
  state_t            state_next;

  logic              slot_free;
  logic              both_empty;
  logic              do_load;
  logic              do_add;
  logic              do_step;
  logic              emit_empty;
  term_t             a_term;
  term_t             b_term;
  logic              a_ok;
  logic              b_ok;
  logic              take_a;
  logic              take_b;
  logic              take_both;
  logic [CNT_W-1:0]  i_next;
  logic [CNT_W-1:0]  j_next;
  logic              step_last;
  logic signed [32:0] step_coeff;
  logic [15:0]       step_power;

  assign slot_free  = !out_valid || !out_stall;
  assign both_empty = (first_count == '0) && (second_count == '0);

  // Heads of both lists
  assign a_term    = first_terms[i_pos[IDX_W-1:0]];
  assign b_term    = second_terms[j_pos[IDX_W-1:0]];
  assign a_ok      = i_pos < first_count;
  assign b_ok      = j_pos < second_count;
  assign take_both = a_ok && b_ok && (a_term.power == b_term.power);
  assign take_a    = a_ok && (!b_ok || (a_term.power > b_term.power));
  assign take_b    = b_ok && (!a_ok || (a_term.power < b_term.power));
  assign i_next    = (take_a || take_both) ? i_pos + 1'b1 : i_pos;
  assign j_next    = (take_b || take_both) ? j_pos + 1'b1 : j_pos;
  assign step_last = !((i_next < first_count) || (j_next < second_count));

  // Select or sum the merged term
  always_comb begin
    if (take_both) begin
      step_coeff = {a_term.coeff[31], a_term.coeff} + {b_term.coeff[31], b_term.coeff};
      step_power = a_term.power;
    end else if (take_a) begin
      step_coeff = {a_term.coeff[31], a_term.coeff};
      step_power = a_term.power;
    end else begin
      step_coeff = {b_term.coeff[31], b_term.coeff};
      step_power = b_term.power;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (q_valid && (q_cmd.op == OP_ADD) && slot_free && !both_empty) begin
          state_next = ST_MERGE;
        end
      end
      ST_MERGE: begin
        if (slot_free && step_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs of the sequencer
  always_comb begin
    do_load = 1'b0;
    do_add  = 1'b0;
    do_step = 1'b0;
    case (state)
      ST_IDLE: begin
        do_load = q_valid && (q_cmd.op != OP_ADD);
        do_add  = q_valid && (q_cmd.op == OP_ADD) && slot_free;
      end
      ST_MERGE: begin
        do_step = slot_free;
      end
      default: ;
    endcase
  end

  assign pop        = do_load || do_add;
  assign emit_empty = do_add && both_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Store counts, drop flag and merge positions
  always_ff @(posedge clk) begin
    if (rst) begin
      first_count  <= '0;
      second_count <= '0;
      dropped_flag <= 1'b0;
      i_pos        <= '0;
      j_pos        <= '0;
    end else begin
      if (do_load) begin
        if (q_cmd.op == OP_LOAD_FIRST) begin
          if (first_count < CNT_W'(MAX_TERMS)) begin
            first_count <= first_count + 1'b1;
          end else begin
            dropped_flag <= 1'b1;
          end
        end else begin
          if (second_count < CNT_W'(MAX_TERMS)) begin
            second_count <= second_count + 1'b1;
          end else begin
            dropped_flag <= 1'b1;
          end
        end
      end
      if (do_add) begin
        i_pos <= '0;
        j_pos <= '0;
      end
      if (emit_empty) begin
        dropped_flag <= 1'b0;
      end
      if (do_step) begin
        i_pos <= i_next;
        j_pos <= j_next;
        if (step_last) begin
          first_count  <= '0;
          second_count <= '0;
          dropped_flag <= 1'b0;
        end
      end
    end
  end

  // Write terms into the stores
  always_ff @(posedge clk) begin
    if (do_load && (q_cmd.op == OP_LOAD_FIRST) && (first_count < CNT_W'(MAX_TERMS))) begin
      first_terms[first_count[IDX_W-1:0]] <= q_cmd.term;
    end
    if (do_load && (q_cmd.op == OP_LOAD_SECOND) && (second_count < CNT_W'(MAX_TERMS))) begin
      second_terms[second_count[IDX_W-1:0]] <= q_cmd.term;
    end
  end

  // Output register: fill on emit, drain when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_empty || do_step) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_empty) begin
      sum_coeff <= '0;
      sum_power <= '0;
      last      <= 1'b1;
      truncated <= dropped_flag;
      empty_res <= 1'b1;
    end else if (do_step) begin
      sum_coeff <= step_coeff;
      sum_power <= step_power;
      last      <= step_last;
      truncated <= dropped_flag;
      empty_res <= 1'b0;
    end
  end

endmodule

### rtl/sparse_polynomial_add_unit.sv
`timescale 1ns / 1ps
// Path: a word is registered in the front hold stage, then in a queue slot;
// a load then writes its store as it is popped. An add of two empty stores
// registers its empty-result word as it is popped; any other add enters the
// merge state, and each merge step registers one result term.
// Loads run one per cycle while idle; an output stall holds the merge.
// Reset: synchronous; clears the queue, counts, drop flag and valid bits.
// ----------------------------------------------------------------------------
// Sparse polynomial add unit
// Loads two sparse polynomials term by term and merges them on command.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_unit #(
  parameter int MAX_TERMS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic signed [31:0] coeff,
  input  logic [15:0]        power,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [32:0] sum_coeff,
  output logic [15:0]        sum_power,
  output logic               last,
  output logic               truncated,
  output logic               empty_res
);
  import spa_pkg::*;

  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  logic q_valid;
  cmd_t q_cmd;

  // Decode and hold incoming words
  spa_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .coeff    (coeff),
    .power    (power),
    .push     (push),
    .push_cmd (push_cmd),
    .q_full   (q_full)
  );

  // Decouple front end from merge engine
  spa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (q_valid),
    .head       (q_cmd)
  );

  // Execute loads and merges
  spa_back #(
    .MAX_TERMS (MAX_TERMS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sum_coeff (sum_coeff),
    .sum_power (sum_power),
    .last      (last),
    .truncated (truncated),
    .empty_res (empty_res)
  );

`ifndef SYNTHESIS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst) !(push && q_full))
    else $error("command pushed into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) !(pop && !q_valid))
    else $error("command popped from empty queue");
  a_empty_form: assert property (@(posedge clk) disable iff (rst)
    (out_valid && empty_res) |-> (last && (sum_coeff == '0) && (sum_power == '0)))
    else $error("empty result word malformed");
  a_reset_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

### verif/sparse_polynomial_add_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sparse polynomial add unit testbench
// Loads term lists into both stores, issues add commands and checks each
// result term against a merge predictor kept in step with accepted words.
// Covers extreme coefficients and powers, zero sums, empty adds, unsorted
// lists, overfilled stores and the unused kind, under varying back-pressure.
// ----------------------------------------------------------------------------
module sparse_polynomial_add_unit_test;
  import spa_pkg::*;

  localparam int          TERM_SLOTS  = 32;
  localparam int          WORD_TARGET = 470;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [31:0] coeff;
    logic [15:0]        power;
  } load_word_t;

  typedef struct packed {
    logic signed [32:0] coeff;
    logic [15:0]        power;
    logic               last;
    logic               trunc;
    logic               empty;
  } sum_term_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         kind = KIND_FIRST;
  logic signed [31:0] coeff = '0;
  logic [15:0]        power = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [32:0] sum_coeff;
  logic [15:0]        sum_power;
  logic               last;
  logic               truncated;
  logic               empty_res;

  load_word_t word_queue[$];
  sum_term_t  sum_terms_due[$];
  load_word_t next_word;
  sum_term_t  seen_term;
  int         words_made = 0;
  int         total_words = 1;
  int         words_taken = 0;
  int         errors = 0;

  // Predictor copy of both term stores
  logic signed [31:0] first_c[TERM_SLOTS];
  logic [15:0]        first_p[TERM_SLOTS];
  logic signed [31:0] second_c[TERM_SLOTS];
  logic [15:0]        second_p[TERM_SLOTS];
  int                 first_n = 0;
  int                 second_n = 0;
  logic               dropped = 1'b0;

  sparse_polynomial_add_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .kind      (kind),
    .coeff     (coeff),
    .power     (power),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sum_coeff (sum_coeff),
    .sum_power (sum_power),
    .last      (last),
    .truncated (truncated),
    .empty_res (empty_res)
  );

  always #2 clk = ~clk;

  // Back-pressure phase follows progress through the word stream
  function automatic int idle_phase();
    if (words_taken * 3 < total_words) return 0;
    if (words_taken * 3 < total_words * 2) return 1;
    return 2;
  endfunction

  function automatic int send_idle_pct();
    case (idle_phase())
      0: return 17;
      1: return 88;
      default: return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct();
    case (idle_phase())
      0: return 88;
      1: return 17;
      default: return 0;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_coeff();
    case ($urandom_range(0, 15))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_word(input logic [1:0] k, input logic signed [31:0] c,
                           input logic [15:0] p);
    word_queue.push_back('{kind: k, coeff: c, power: p});
    if (k != KIND_UNUSED) words_made++;
  endtask

  // Build two descending (occasionally unsorted) lists, interleave their loads, then add
  task automatic queue_poly_pair();
    int          n1;
    int          n2;
    int          i;
    int          j;
    int          step_max;
    int          base;
    int          p;
    bit          unsorted;
    logic [15:0] p1[$];
    logic [15:0] p2[$];
    n1 = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 6);
    n2 = ($urandom_range(0, 9) == 0) ? $urandom_range(28, 40) : $urandom_range(0, 6);
    unsorted = ($urandom_range(0, 9) == 0);
    if ($urandom_range(0, 1)) begin
      step_max = 3;
      base = $urandom_range(120, 65535);
    end else begin
      step_max = 1500;
      base = $urandom_range(60000, 65535);
    end
    p = base;
    for (i = 0; i < n1; i++) begin
      p1.push_back(unsorted ? 16'($urandom_range(0, 7)) : 16'(p));
      p -= $urandom_range(1, step_max);
    end
    p = base;
    for (i = 0; i < n2; i++) begin
      p2.push_back(unsorted ? 16'($urandom_range(0, 7)) : 16'(p));
      p -= $urandom_range(1, step_max);
    end
    i = 0;
    j = 0;
    while (i < n1 || j < n2) begin
      if ($urandom_range(0, 19) == 0)
        push_word(KIND_UNUSED, $urandom, 16'($urandom));
      if (j == n2 || (i < n1 && $urandom_range(0, 1))) begin
        push_word(KIND_FIRST, pick_coeff(), p1[i]);
        i++;
      end else begin
        push_word(KIND_SECOND, pick_coeff(), p2[j]);
        j++;
      end
    end
    push_word(KIND_ADD, $urandom, 16'($urandom));
  endtask

  // Apply one accepted word to the predictor; an add yields merged terms
  task automatic apply_word(input logic [1:0] k, input logic signed [31:0] c,
                            input logic [15:0] p);
    int          i;
    int          j;
    longint      rc;
    logic [15:0] rp;
    sum_term_t   t;
    case (k)
      KIND_FIRST: begin
        if (first_n < TERM_SLOTS) begin
          first_c[first_n] = c;
          first_p[first_n] = p;
          first_n++;
        end else begin
          dropped = 1'b1;
        end
      end
      KIND_SECOND: begin
        if (second_n < TERM_SLOTS) begin
          second_c[second_n] = c;
          second_p[second_n] = p;
          second_n++;
        end else begin
          dropped = 1'b1;
        end
      end
      KIND_ADD: begin
        if (first_n == 0 && second_n == 0) begin
          sum_terms_due.push_back('{coeff: '0, power: '0, last: 1'b1,
                                    trunc: dropped, empty: 1'b1});
        end else begin
          i = 0;
          j = 0;
          while (i < first_n || j < second_n) begin
            if (i < first_n && j < second_n && first_p[i] > second_p[j]) begin
              rc = longint'(first_c[i]);
              rp = first_p[i];
              i++;
            end else if (i < first_n && j < second_n && first_p[i] < second_p[j]) begin
              rc = longint'(second_c[j]);
              rp = second_p[j];
              j++;
            end else if (i < first_n && j < second_n) begin
              rc = longint'(first_c[i]) + longint'(second_c[j]);
              rp = first_p[i];
              i++;
              j++;
            end else if (i < first_n) begin
              rc = longint'(first_c[i]);
              rp = first_p[i];
              i++;
            end else begin
              rc = longint'(second_c[j]);
              rp = second_p[j];
              j++;
            end
            t.coeff = rc[32:0];
            t.power = rp;
            t.last  = !(i < first_n || j < second_n);
            t.trunc = dropped;
            t.empty = 1'b0;
            sum_terms_due.push_back(t);
          end
        end
        first_n  = 0;
        second_n = 0;
        dropped  = 1'b0;
      end
      default: ;
    endcase
  endtask

  function automatic void compare_field(input string name,
                                        input logic signed [32:0] want,
                                        input logic signed [32:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Driver: hold a stalled word, otherwise present the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_word(kind, coeff, power);
        words_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (word_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct()) begin
          next_word = word_queue.pop_front();
          in_valid <= 1'b1;
          kind     <= next_word.kind;
          coeff    <= next_word.coeff;
          power    <= next_word.power;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct());
    end
  end

  // Monitor: check each accepted result word against the oldest due term
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (sum_terms_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual coeff %0d power %0d",
                 $time, sum_coeff, sum_power);
      end else begin
        seen_term = sum_terms_due.pop_front();
        compare_field("sum_coeff", seen_term.coeff, sum_coeff);
        compare_field("sum_power", 33'(seen_term.power), 33'(sum_power));
        compare_field("last", 33'(seen_term.last), 33'(last));
        compare_field("truncated", 33'(seen_term.trunc), 33'(truncated));
        compare_field("empty_res", 33'(seen_term.empty), 33'(empty_res));
      end
    end
  end

  initial begin
    // Directed: empty add, unused kind, extreme sums, zero sum, tail copy
    push_word(KIND_ADD, $urandom, 16'($urandom));
    push_word(KIND_UNUSED, 32'sh7FFF_FFFF, 16'hFFFF);
    push_word(KIND_FIRST, 32'sh7FFF_FFFF, 16'hFFFF);
    push_word(KIND_SECOND, 32'sh7FFF_FFFF, 16'hFFFF);
    push_word(KIND_FIRST, 32'sh8000_0000, 16'd100);
    push_word(KIND_SECOND, 32'sh8000_0000, 16'd100);
    push_word(KIND_FIRST, 32'sd5, 16'd7);
    push_word(KIND_SECOND, -32'sd5, 16'd7);
    push_word(KIND_SECOND, 32'sd3, 16'd2);
    push_word(KIND_SECOND, 32'sd1, 16'd0);
    push_word(KIND_ADD, $urandom, 16'($urandom));
    // Unsorted first list against a single second term
    push_word(KIND_FIRST, 32'sd9, 16'd3);
    push_word(KIND_FIRST, 32'sd4, 16'd10);
    push_word(KIND_UNUSED, '0, '0);
    push_word(KIND_SECOND, 32'sd2, 16'd5);
    push_word(KIND_ADD, $urandom, 16'($urandom));
    // First list only, second list only
    push_word(KIND_FIRST, -32'sd1, 16'd0);
    push_word(KIND_ADD, $urandom, 16'($urandom));
    push_word(KIND_SECOND, 32'sh8000_0000, 16'hFFFF);
    push_word(KIND_SECOND, 32'sh7FFF_FFFF, 16'd0);
    push_word(KIND_ADD, $urandom, 16'($urandom));
    push_word(KIND_ADD, $urandom, 16'($urandom));

    while (words_made < WORD_TARGET) queue_poly_pair();
    total_words = word_queue.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (word_queue.size() != 0 || in_valid) @(posedge clk);
    while (sum_terms_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (errors == 0 && sum_terms_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### sparse_polynomial_add_unit.f
rtl/spa_pkg.sv
rtl/spa_front.sv
rtl/spa_queue.sv
rtl/spa_back.sv
rtl/sparse_polynomial_add_unit.sv
verif/sparse_polynomial_add_unit_test.sv
